/* rtl/pse_pkg.sv */
package pse_pkg;

    // operand stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    // character codes
    localparam logic [7:0] SYM_ZERO  = 8'h30;
    localparam logic [7:0] SYM_NINE  = 8'h39;
    localparam logic [7:0] SYM_PLUS  = 8'h2b;
    localparam logic [7:0] SYM_MINUS = 8'h2d;
    localparam logic [7:0] SYM_MUL   = 8'h2a;
    localparam logic [7:0] SYM_DIV   = 8'h2f;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNDERFLOW = 3'd1,
        ERR_DIVZERO   = 3'd2,
        ERR_EMPTY     = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_LEFT,
        ST_EXEC,
        ST_DIV,
        ST_FINAL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } rsp_t;

    // divider request from the sequencer
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

endpackage

/* rtl/pse_ram.sv */
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/pse_div.sv */
module pse_div
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              done,
    output logic [DATA_W-1:0] quo
);

    localparam int ITER_W = $clog2(DATA_W + 1);

    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] dmag_reg, dmag_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dmag_next = dmag_reg;
        shifted   = {rem_reg, q_reg[DATA_W-1]};
        trial     = shifted - {1'b0, dmag_reg};
        if (req.start)
        begin
            neg_next  = req.num[DATA_W-1] ^ req.den[DATA_W-1];
            q_next    = req.num[DATA_W-1] ? (~req.num + 1'b1) : req.num;
            dmag_next = req.den[DATA_W-1] ? (~req.den + 1'b1) : req.den;
            rem_next  = '0;
            iter_next = ITER_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], 1'b0};
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dmag_reg <= dmag_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

/* rtl/postfix_stack_evaluator_core.sv */
// Postfix (reverse Polish) expression evaluator. One ASCII character enters per item: a digit
// pushes 0..9 on an operand stack of STACK_DEPTH 32-bit entries held in a single-port-read
// synchronous RAM; + - * / pop the right then the left operand and push the wrapping 32-bit
// result (division truncates toward zero, most negative / -1 wraps); any other character is
// ignored. The item marked last produces one result item: the top of the stack with status 0,
// or value -1 with status 1 operand underflow, 2 divide by zero, 3 empty at end, 4 stack
// overflow. The first error sticks and later characters are skipped until the last item, after
// which stack and error clear. Items are taken one at a time: a digit or ignored character is
// handled in the decode state, + - * make two stack reads and one write back, / reads both
// operands too and takes the quotient from a restoring divider that makes one bit per cycle;
// the last item reads the top of stack into the output register, waiting while an earlier
// result still sits there stalled. A finished result waits in that register while the next
// item is already being taken.
module postfix_stack_evaluator_core
    import pse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    status_t           err_reg, err_next;
    logic [7:0]        sym_reg;
    logic              last_reg;
    logic [DATA_W-1:0] right_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_data_reg, rsp_data_next;

    // stack ram control
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // divider
    div_req_t          div_req;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              is_digit;
    logic              is_op;
    logic [DATA_W-1:0] alu_res;
    logic              accept;

    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign is_digit = (sym_reg >= SYM_ZERO) && (sym_reg <= SYM_NINE);
    assign is_op    = (sym_reg == SYM_PLUS) || (sym_reg == SYM_MINUS) ||
                      (sym_reg == SYM_MUL) || (sym_reg == SYM_DIV);
    assign accept   = req_valid && !req_stall;

    // left operand comes straight from the ram read register
    always_comb
    begin
        case (sym_reg)
            SYM_PLUS:  alu_res = ram_rdata + right_reg;
            SYM_MINUS: alu_res = ram_rdata - right_reg;
            default:   alu_res = ram_rdata * right_reg;
        endcase
    end

    // sequencer: read, modify, write back one stack entry at a time
    always_comb
    begin
        logic item_done;
        item_done      = 1'b0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = DATA_W'(sym_reg - SYM_ZERO);
        ram_re         = 1'b0;
        ram_raddr      = cnt_m1[ADDR_W-1:0];
        div_req.start  = 1'b0;
        div_req.num    = ram_rdata;
        div_req.den    = right_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (err_reg != ERR_NONE)
                begin
                    // sticky error: skip until the last item
                    item_done = 1'b1;
                end
                else if (is_digit)
                begin
                    if (cnt_reg == CNT_W'(STACK_DEPTH))
                    begin
                        err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    item_done = 1'b1;
                end
                else if (is_op)
                begin
                    if (cnt_reg < CNT_W'(2))
                    begin
                        err_next  = ERR_UNDERFLOW;
                        item_done = 1'b1;
                    end
                    else
                    begin
                        // fetch the right operand
                        ram_re     = 1'b1;
                        state_next = ST_RD_LEFT;
                    end
                end
                else
                begin
                    item_done = 1'b1;
                end
            end
            ST_RD_LEFT:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cnt_m2[ADDR_W-1:0];
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (sym_reg == SYM_DIV)
                begin
                    if (right_reg == '0)
                    begin
                        // both operands are consumed
                        err_next  = ERR_DIVZERO;
                        cnt_next  = cnt_m2;
                        item_done = 1'b1;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m2[ADDR_W-1:0];
                    ram_wdata = alu_res;
                    cnt_next  = cnt_m1;
                    item_done = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m2[ADDR_W-1:0];
                    ram_wdata = div_quo;
                    cnt_next  = cnt_m1;
                    item_done = 1'b1;
                end
            end
            ST_FINAL:
            begin
                // read top of stack when the result needs it
                if ((err_reg == ERR_NONE) && (cnt_reg != '0))
                begin
                    ram_re = 1'b1;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (err_reg != ERR_NONE)
                    begin
                        rsp_data_next.value  = '1;
                        rsp_data_next.status = err_reg;
                    end
                    else if (cnt_reg == '0)
                    begin
                        rsp_data_next.value  = '1;
                        rsp_data_next.status = ERR_EMPTY;
                    end
                    else
                    begin
                        rsp_data_next.value  = ram_rdata;
                        rsp_data_next.status = ERR_NONE;
                    end
                    cnt_next   = '0;
                    err_next   = ERR_NONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (item_done)
        begin
            state_next = last_reg ? ST_FINAL : ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ERR_NONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg  <= req_data.symbol;
            last_reg <= req_data.last;
        end
        if (state_reg == ST_RD_LEFT)
        begin
            right_reg <= ram_rdata;
        end
        rsp_data_reg <= rsp_data_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // stack count stays within the ram
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // no read and write of the stack in the same cycle
    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("stack read and write overlap");

    // a quotient only arrives while the sequencer waits for it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // a delivered result leaves the stack cleared
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && (!rsp_valid_reg || !rsp_stall))
        |=> ((cnt_reg == '0) && (err_reg == ERR_NONE) && rsp_valid_reg))
        else $error("stack not cleared after result");

endmodule
